// ===== src/dbcw_pkg.sv =====
// Shared types, constants and helpers for the delay-based congestion window unit.
package dbcw_pkg;

    localparam int TABLE_DEPTH_DEF    = 256;
    localparam int RATE_FRAC_BITS_DEF = 16;

    // shared divider: 48-bit dividend, 32-bit divisor, one quotient bit per cycle
    localparam int DIV_W     = 48;
    localparam int DIVISOR_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [15:0] DELAY_THR_RST = 16'd120;
    localparam logic [15:0] DECR_RST      = 16'd55706;
    localparam logic [15:0] MIN_TO_RST    = 16'd50;
    localparam logic [15:0] MAX_TO_RST    = 16'd5000;
    localparam logic [15:0] INIT_WIN_RST  = 16'd2;
    localparam logic [15:0] TIMEOUT_RST   = 16'd1000;

    localparam logic KIND_SENT = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef enum logic [2:0]
    {
        REG_DELAY_THR = 3'd0,
        REG_DECR      = 3'd1,
        REG_MIN_TO    = 3'd2,
        REG_MAX_TO    = 3'd3,
        REG_INIT_WIN  = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_DISPATCH,
        ST_SEND,
        ST_ENTRY,
        ST_RATE,
        ST_CHANGE,
        ST_AVG,
        ST_SELECT,
        ST_GROW,
        ST_RTT,
        ST_RTO,
        ST_CUT,
        ST_OUT
    } state_t;

    typedef struct packed
    {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    function automatic logic signed [47:0] sat48(input logic signed [59:0] x);
        logic signed [47:0] r;
        if (x > 60'sh7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (x < -60'sh8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = x[47:0];
        return r;
    endfunction

endpackage

// ===== src/delay_based_congestion_window_unit.sv =====
// Delay-based congestion window controller with RFC 6298 retransmission timeout.
//
// Each request yields exactly one result. An ack takes longer than a sent
// request, as the shared bit-serial divider works out its rate, and longer still
// when the window grows in congestion avoidance, as the divider then also works
// out the window step. When TABLE_DEPTH is not a power of two the slot index
// is fixed up by a reciprocal multiply, in an extra ST_SLOT state per request.
// A stalled result holds the unit, and the unit goes back to idle after each
// result before the next request is taken.
// After reset the occupancy table is cleared one entry a cycle, during which
// no request is taken; configuration writes are taken at any time but are meant
// for idle periods only.
module delay_based_congestion_window_unit
    import dbcw_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] seq_num,
    input  logic [31:0] send_time_ms,
    input  logic [31:0] ack_time_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] window_datagrams,
    output logic [15:0] timeout_value_ms,
    output logic        in_slow_start,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam bit POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic signed [47:0] AVG_RST = 48'sd10 <<< RATE_FRAC_BITS;
    // ceil(2^REC_SH / TABLE_DEPTH) gives an exact quotient for any 32-bit number
    localparam int REC_SH = 32 + IDX_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << REC_SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [31:0]      quo_reg;
    logic             kind_reg;
    logic [31:0]      delay_reg;

    logic [15:0] thr_reg, decr_reg, min_to_reg, max_to_reg, init_win_reg;

    logic [31:0]        window_reg;
    logic               slow_reg, first_reg;
    logic signed [47:0] prev_rate_reg, avg_reg, change_reg;
    logic [39:0]        srtt_reg, var_reg;
    logic [15:0]        timeout_reg, occ_reg;

    logic        out_valid_reg;
    logic [15:0] out_win_reg, out_to_reg;
    logic        out_slow_reg;

    logic [16:0] mem [TABLE_DEPTH];
    logic [16:0] rd_data_reg;
    logic        mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [16:0] mem_wdata;

    div_req_t             div_req;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_quot;

    logic        accept, out_load;
    logic [31:0] delay_raw;
    logic [64:0] recip_prod;
    logic [IDX_W-1:0] slot_sub;
    logic [15:0] occ_inc, occ_dec, entry;
    logic signed [59:0] rate_x, prev_x, diff_x, prod_x;
    logic signed [59:0] chg_x, avg_x, avg_sum, tc_x, t6_x, t3_x;
    logic signed [47:0] change_new, avg_new;
    logic [1:0]  step_k;
    logic [48:0] grow_sum;
    logic [32:0] slow_sum;
    logic [31:0] win_div;
    logic [39:0] d40, rtt_diff;
    logic [41:0] var_sum;
    logic [42:0] srtt_sum, rto, min_x, max_x;
    logic [47:0] cut_prod;

    dbcw_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .busy      (div_busy),
        .quotient  (div_quot)
    );

    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // datapath arithmetic
    always_comb
    begin
        delay_raw  = ack_time_ms - send_time_ms;
        recip_prod = {33'd0, seq_num} * {32'd0, RECIP[32:0]};
        slot_sub   = IDX_W'(quo_reg[IDX_W-1:0] * IDX_W'(TABLE_DEPTH));
        occ_inc    = (occ_reg != 16'hFFFF) ? occ_reg + 16'd1 : occ_reg;
        occ_dec    = (occ_reg != 16'd0) ? occ_reg - 16'd1 : occ_reg;
        entry      = rd_data_reg[16] ? rd_data_reg[15:0] : 16'd0;

        rate_x     = 60'(signed'(div_quot));
        prev_x     = 60'(prev_rate_reg);
        diff_x     = rate_x - prev_x;
        prod_x     = (diff_x <<< 10) - (diff_x <<< 4) - (diff_x <<< 3);
        change_new = sat48(prod_x);

        chg_x   = 60'(change_reg);
        avg_x   = 60'(avg_reg);
        avg_sum = chg_x + (avg_x <<< 3) - avg_x;
        avg_new = sat48(avg_sum >>> 3);

        tc_x = (chg_x <<< 3) + (chg_x <<< 1);
        t6_x = (avg_x <<< 2) + (avg_x <<< 1);
        t3_x = (avg_x <<< 1) + avg_x;
        if (tc_x > t6_x)
            step_k = 2'd3;
        else if (tc_x > t3_x)
            step_k = 2'd2;
        else if (chg_x > 60'sd0)
            step_k = 2'd1;
        else
            step_k = 2'd0;

        win_div  = (window_reg != 32'd0) ? window_reg : 32'd1;
        grow_sum = {17'd0, window_reg} + {1'b0, div_quot};
        slow_sum = {1'b0, window_reg} + 33'h1_0000;

        d40      = {delay_reg, 8'd0};
        rtt_diff = (srtt_reg > d40) ? srtt_reg - d40 : d40 - srtt_reg;
        var_sum  = ({2'd0, var_reg} << 1) + {2'd0, var_reg} + {2'd0, rtt_diff};
        srtt_sum = ({3'd0, srtt_reg} << 3) - {3'd0, srtt_reg} + {3'd0, d40};
        rto      = {3'd0, srtt_reg} + {1'b0, var_reg, 2'd0};
        min_x    = {19'd0, min_to_reg, 8'd0};
        max_x    = {19'd0, max_to_reg, 8'd0};

        cut_prod = window_reg * decr_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                    state_next = POW2 ? ST_DISPATCH : ST_SLOT;
            ST_SLOT:
                state_next = ST_DISPATCH;
            ST_DISPATCH:
                state_next = (kind_reg == KIND_ACK) ? ST_ENTRY : ST_SEND;
            ST_SEND:
                state_next = ST_OUT;
            ST_ENTRY:
                state_next = ST_RATE;
            ST_RATE:
                if (!div_busy)
                    state_next = ST_CHANGE;
            ST_CHANGE:
                state_next = ST_AVG;
            ST_AVG:
                state_next = ST_SELECT;
            ST_SELECT:
                state_next = (!slow_reg && step_k != 2'd0) ? ST_GROW : ST_RTT;
            ST_GROW:
                if (!div_busy)
                    state_next = ST_RTT;
            ST_RTT:
                state_next = ST_RTO;
            ST_RTO:
                state_next = ST_CUT;
            ST_CUT:
                state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs: handshake, divider requests, table port
    always_comb
    begin
        in_stall         = (state_reg != ST_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        mem_we           = 1'b0;
        mem_addr         = slot_reg;
        mem_wdata        = 17'd0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            ST_SEND:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, occ_inc};
            end
            ST_ENTRY:
            begin
                // take the snapshot and drop the slot
                mem_we           = 1'b1;
                div_req.start    = 1'b1;
                div_req.dividend = {32'd0, entry} << RATE_FRAC_BITS;
                div_req.divisor  = delay_reg;
            end
            ST_SELECT:
            begin
                div_req.start    = !slow_reg && step_k != 2'd0;
                div_req.dividend = {14'd0, step_k, 32'd0};
                div_req.divisor  = win_div;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            thr_reg       <= DELAY_THR_RST;
            decr_reg      <= DECR_RST;
            min_to_reg    <= MIN_TO_RST;
            max_to_reg    <= MAX_TO_RST;
            init_win_reg  <= INIT_WIN_RST;
            window_reg    <= {INIT_WIN_RST, 16'd0};
            slow_reg      <= 1'b1;
            first_reg     <= 1'b1;
            prev_rate_reg <= '0;
            avg_reg       <= AVG_RST;
            change_reg    <= '0;
            srtt_reg      <= '0;
            var_reg       <= '0;
            timeout_reg   <= TIMEOUT_RST;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_win_reg   <= INIT_WIN_RST;
            out_to_reg    <= TIMEOUT_RST;
            out_slow_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;

            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DELAY_THR: thr_reg <= cfg_data;
                    REG_DECR:      decr_reg <= cfg_data;
                    REG_MIN_TO:    min_to_reg <= cfg_data;
                    REG_MAX_TO:    max_to_reg <= cfg_data;
                    REG_INIT_WIN:
                    begin
                        init_win_reg <= cfg_data;
                        window_reg   <= {cfg_data, 16'd0};
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                ST_SEND:
                    occ_reg <= occ_inc;
                ST_ENTRY:
                    occ_reg <= occ_dec;
                ST_CHANGE:
                begin
                    change_reg    <= change_new;
                    prev_rate_reg <= signed'(div_quot);
                end
                ST_AVG:
                    avg_reg <= avg_new;
                ST_SELECT:
                    if (slow_reg)
                        window_reg <= slow_sum[32] ? 32'hFFFF_FFFF : slow_sum[31:0];
                ST_GROW:
                    if (!div_busy)
                        window_reg <= (grow_sum[48:32] != 17'd0) ? 32'hFFFF_FFFF
                                                                 : grow_sum[31:0];
                ST_RTT:
                begin
                    first_reg <= 1'b0;
                    if (first_reg)
                    begin
                        srtt_reg <= d40;
                        var_reg  <= {1'b0, d40[39:1]};
                    end
                    else
                    begin
                        srtt_reg <= srtt_sum[42:3];
                        var_reg  <= var_sum[41:2];
                    end
                end
                ST_RTO:
                    if (rto < min_x)
                        timeout_reg <= min_to_reg;
                    else if (rto > max_x)
                        timeout_reg <= max_to_reg;
                    else
                        timeout_reg <= rto[23:8];
                ST_CUT:
                    if (delay_reg > {16'd0, thr_reg})
                    begin
                        slow_reg   <= 1'b0;
                        window_reg <= cut_prod[47:16];
                    end
                default:
                begin
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_win_reg   <= window_reg[31:16];
                out_to_reg    <= timeout_reg;
                out_slow_reg  <= slow_reg;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // request capture; slot is the low bits less the low bits of quotient times depth
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            delay_reg <= (delay_raw == 32'd0) ? 32'd1 : delay_raw;
            slot_reg  <= seq_num[IDX_W-1:0];
            quo_reg   <= 32'(recip_prod >> REC_SH);
        end
        else if (state_reg == ST_SLOT)
            slot_reg <= slot_reg - slot_sub;
    end

    assign out_valid        = out_valid_reg;
    assign window_datagrams = out_win_reg;
    assign timeout_value_ms = out_to_reg;
    assign in_slow_start    = out_slow_reg;

endmodule

// ===== src/dbcw_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module dbcw_div
    import dbcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DIVISOR_W-1:0] r_reg, r_next;
    logic [DIVISOR_W-1:0] d_reg, d_next;
    logic [DIVISOR_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[DIV_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DIVISOR_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DIVISOR_W-1:0];
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ===== src/dbcw_checker.sv =====
// Port-level checks for the congestion window unit, bound to the top level.
module dbcw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] window_datagrams,
    input logic [15:0] timeout_value_ms,
    input logic        in_slow_start
);

    // a taken request makes the unit busy on the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken on consecutive cycles");

    // slow start never resumes
    a_slow_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        !in_slow_start |=> !in_slow_start)
        else $error("slow start re-entered");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(window_datagrams)
            && $stable(timeout_value_ms) && $stable(in_slow_start))
        else $error("stalled result changed");

endmodule

bind delay_based_congestion_window_unit dbcw_checker u_dbcw_checker (.*);

// ===== verif/delay_based_congestion_window_unit_test.sv =====
// Self-checking testbench for the delay-based congestion window unit.
module delay_based_congestion_window_unit_test;
    import dbcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = TABLE_DEPTH_DEF;
    localparam int QFRAC = RATE_FRAC_BITS_DEF;

    typedef struct packed
    {
        logic [15:0] window;
        logic [15:0] timeout;
        logic        slow;
    } cc_status_t;

    // Predicts the status after each request and checks the results in order.
    class window_scoreboard;
        logic [15:0] thr_ms, decr, min_to, max_to, init_win;
        logic [31:0] win_q;
        bit          ss_active, first_rtt;
        longint      prev_rate, avg_change;
        longint unsigned srtt, rttvar;
        logic [15:0] rto_ms, occupancy;
        logic [15:0] occ_table[SLOTS];
        bit          occ_valid[SLOTS];
        cc_status_t  pending[$];
        int          errors;

        function new();
            thr_ms = DELAY_THR_RST;
            decr = DECR_RST;
            min_to = MIN_TO_RST;
            max_to = MAX_TO_RST;
            init_win = INIT_WIN_RST;
            win_q = {init_win, 16'd0};
            ss_active = 1;
            first_rtt = 1;
            prev_rate = 0;
            avg_change = longint'(10) << QFRAC;
            srtt = 0;
            rttvar = 0;
            rto_ms = TIMEOUT_RST;
            occupancy = 0;
            foreach (occ_valid[i])
            begin
                occ_valid[i] = 0;
                occ_table[i] = 0;
            end
            errors = 0;
        endfunction

        function longint clip48(longint x);
            longint hi;
            hi = (longint'(1) << 47) - 1;
            if (x > hi)
                return hi;
            if (x < -hi - 1)
                return -hi - 1;
            return x;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [15:0] v);
            case (idx)
                REG_DELAY_THR: thr_ms = v;
                REG_DECR:      decr = v;
                REG_MIN_TO:    min_to = v;
                REG_MAX_TO:    max_to = v;
                REG_INIT_WIN:
                begin
                    init_win = v;
                    win_q = {v, 16'd0};
                end
                default: ;
            endcase
        endfunction

        function void add_step(longint unsigned step);
            longint unsigned w;
            w = longint'(win_q) + step;
            win_q = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
        endfunction

        function void note_request(logic k, logic [31:0] seq, logic [31:0] ts,
                                   logic [31:0] ta);
            int unsigned slot;
            logic [15:0] entry;
            logic [31:0] delay;
            longint rate, change, s, dv;
            longint unsigned wd, d, diff, rto;
            slot = seq % SLOTS;
            if (k == KIND_SENT)
            begin
                if (occupancy != 16'hFFFF)
                    occupancy++;
                occ_table[slot] = occupancy;
                occ_valid[slot] = 1;
            end
            else
            begin
                entry = occ_valid[slot] ? occ_table[slot] : 16'd0;
                occ_valid[slot] = 0;
                if (occupancy != 0)
                    occupancy--;
                delay = ta - ts;
                if (delay == 0)
                    delay = 1;
                rate = longint'((longint'(entry) << QFRAC) / longint'(delay));
                change = clip48(1000 * (rate - prev_rate));
                s = change + 7 * avg_change;
                dv = (s >= 0) ? (s >>> 3) : -((-s + 7) >>> 3);
                avg_change = clip48(dv);
                wd = (win_q != 0) ? longint'(win_q) : 1;
                if (ss_active)
                    add_step(65536);
                else if (10 * change > 6 * avg_change)
                    add_step((longint'(3) << 32) / wd);
                else if (10 * change > 3 * avg_change)
                    add_step((longint'(2) << 32) / wd);
                else if (change > 0)
                    add_step((longint'(1) << 32) / wd);
                prev_rate = rate;
                d = longint'(delay) << 8;
                if (first_rtt)
                begin
                    srtt = d;
                    rttvar = d >> 1;
                    first_rtt = 0;
                end
                else
                begin
                    diff = (srtt > d) ? srtt - d : d - srtt;
                    rttvar = (3 * rttvar + diff) >> 2;
                    srtt = (7 * srtt + d) >> 3;
                end
                rto = srtt + 4 * rttvar;
                if (rto < (longint'(min_to) << 8))
                    rto_ms = min_to;
                else if (rto > (longint'(max_to) << 8))
                    rto_ms = max_to;
                else
                    rto_ms = rto[23:8];
                if (delay > thr_ms)
                begin
                    ss_active = 0;
                    win_q = 32'((longint'(win_q) * decr) >> 16);
                end
            end
            pending.push_back('{win_q[31:16], rto_ms, ss_active});
        endfunction

        function void check_status(cc_status_t got);
            cc_status_t exp_s;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %p", got);
                return;
            end
            exp_s = pending.pop_front();
            if (got !== exp_s)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: window exp %0d got %0d, timeout exp %0d got %0d, %s",
                        exp_s.window, got.window, exp_s.timeout, got.timeout,
                        $sformatf("slow exp %0d got %0d", exp_s.slow, got.slow));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] seq_num;
    logic [31:0] send_time_ms;
    logic [31:0] ack_time_ms;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] window_datagrams;
    logic [15:0] timeout_value_ms;
    logic        in_slow_start;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    window_scoreboard sb;
    bit          hold_off;
    bit          stim_done;
    logic [31:0] next_seq;
    logic [31:0] clock_ms;
    logic [31:0] sent_seq[$];
    logic [31:0] sent_at[$];

    delay_based_congestion_window_unit u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .seq_num          (seq_num),
        .send_time_ms     (send_time_ms),
        .ack_time_ms      (ack_time_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .window_datagrams (window_datagrams),
        .timeout_value_ms (timeout_value_ms),
        .in_slow_start    (in_slow_start),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_status('{window_datagrams, timeout_value_ms, in_slow_start});
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial
    begin
        int mode;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall = 1;
                repeat (3000) @(negedge clk);
                hold_off = 0;
                out_stall = 0;
            end
            else
            begin
                mode = int'(clock_ms[12:11]);
                case (mode)
                    0: out_stall = 0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    default: out_stall = ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    task automatic send_request(logic k, logic [31:0] seq, logic [31:0] ts, logic [31:0] ta);
        kind = k;
        seq_num = seq;
        send_time_ms = ts;
        ack_time_ms = ta;
        in_valid = 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(k, seq, ts, ta);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
        cfg_write = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 0;
        sb.write_reg(idx, v);
    endtask

    // Random content: mostly send/ack pairs with realistic timing, some noise.
    task automatic random_request();
        int pick;
        logic [31:0] s, t;
        int idx;
        pick = $urandom_range(0, 99);
        clock_ms += $urandom_range(0, 20);
        if (pick < 45 && sent_seq.size() < 200)
        begin
            sent_seq.push_back(next_seq);
            sent_at.push_back(clock_ms);
            send_request(KIND_SENT, next_seq, $urandom, $urandom);
            next_seq++;
        end
        else if (pick < 88 && sent_seq.size() != 0)
        begin
            idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sent_seq.size() - 1) : 0;
            s = sent_seq[idx];
            t = sent_at[idx];
            sent_seq.delete(idx);
            sent_at.delete(idx);
            send_request(KIND_ACK, s, t, t + $urandom_range(0, 250));
        end
        else
            send_request(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
    endtask

    task automatic random_config();
        write_reg(REG_DELAY_THR,
            16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(20, 260)));
        write_reg(REG_DECR,
            16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(32768, 65535)));
        write_reg(REG_MIN_TO, 16'($urandom_range(0, 400)));
        write_reg(REG_MAX_TO, 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 100)
                                                               : $urandom_range(300, 65535)));
        write_reg(REG_INIT_WIN, 16'(($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535)
                                                                 : $urandom_range(1, 20)));
    endtask

    initial
    begin
        int i, gap, burst, next_cfg;
        bit held, paused;
        sb = new();
        hold_off = 0;
        stim_done = 0;
        next_seq = 0;
        clock_ms = 0;
        rst_n = 0;
        in_valid = 0;
        kind = KIND_SENT;
        seq_num = 0;
        send_time_ms = 0;
        ack_time_ms = 0;
        cfg_write = 0;
        cfg_index = REG_DELAY_THR;
        cfg_data = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;

        // Directed: field extremes, aliasing, unmatched ack, zero delay, occupancy floor.
        send_request(KIND_ACK, 32'd7, 32'd100, 32'd100);
        send_request(KIND_SENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_SENT, 32'h0000_00FF, 32'd0, 32'd0);
        send_request(KIND_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_request(KIND_ACK, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_request(KIND_SENT, 32'd1, 32'd0, 32'd0);
        send_request(KIND_ACK, 32'd1, 32'd10, 32'd15);
        send_request(KIND_ACK, 32'd2, 32'd10, 32'd9);
        wait_drained();
        write_reg(REG_INIT_WIN, 16'd0);
        write_reg(REG_DELAY_THR, 16'd0);
        write_reg(REG_DECR, 16'd0);
        write_reg(REG_MIN_TO, 16'd65535);
        write_reg(REG_MAX_TO, 16'd0);
        send_request(KIND_SENT, 32'd3, 32'd0, 32'd0);
        send_request(KIND_ACK, 32'd3, 32'd0, 32'd2);
        send_request(KIND_ACK, 32'd4, 32'd0, 32'd0);
        wait_drained();
        write_reg(REG_INIT_WIN, 16'd65535);
        write_reg(REG_DECR, 16'd65535);
        write_reg(REG_MIN_TO, 16'd0);
        write_reg(REG_MAX_TO, 16'd65535);
        write_reg(REG_DELAY_THR, 16'd65535);
        for (i = 0; i < 6; i++)
            send_request(KIND_SENT, 32'd10 + i, 32'd0, 32'd0);
        for (i = 0; i < 6; i++)
            send_request(KIND_ACK, 32'd10 + i, 32'd0, 32'd1 + i * 40);
        wait_drained();
        write_reg(REG_DELAY_THR, DELAY_THR_RST);
        write_reg(REG_DECR, DECR_RST);
        write_reg(REG_MIN_TO, MIN_TO_RST);
        write_reg(REG_MAX_TO, MAX_TO_RST);
        write_reg(REG_INIT_WIN, INIT_WIN_RST);

        // Random phases with configuration changes between them.
        i = 0;
        next_cfg = 299;
        held = 0;
        paused = 0;
        while (i < 1400)
        begin
            if (i >= next_cfg)
            begin
                wait_drained();
                random_config();
                next_cfg += 300;
            end
            if (!held && i >= 500)
            begin
                held = 1;
                hold_off = 1;
            end
            if (!paused && i >= 800)
            begin
                paused = 1;
                wait_drained();
            end
            burst = $urandom_range(1, 20);
            while (burst > 0 && i < 1400)
            begin
                random_request();
                burst--;
                i++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
            repeat (gap) @(negedge clk);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
